[src/hcbt_pkg.sv]
// Shared types, constants and symbol mapping functions for the Hill block transform.
// No dependencies; used by the interfaces, the cell and the top level.
package hcbt_pkg;

   localparam int CharW     = 8;
   localparam int SymW      = 6;
   localparam int SymCount  = 45;
   localparam int KeyEntryW = 6;
   localparam int KeyCols   = 4;
   localparam int KeyRows   = 4;
   localparam int KeyRowW   = 24;
   localparam int BlockSizeW = 3;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 24;

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrBlockSize = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrKeyRow0   = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrKeyRow1   = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrKeyRow2   = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrKeyRow3   = 3'd4;

   // reset values: block of two, identity key
   localparam logic [BlockSizeW-1:0] BlockSizeReset = 3'd2;
   localparam logic [KeyRowW-1:0] KeyRow0Reset = 24'd1;
   localparam logic [KeyRowW-1:0] KeyRow1Reset = 24'd64;
   localparam logic [KeyRowW-1:0] KeyRow2Reset = 24'd4096;
   localparam logic [KeyRowW-1:0] KeyRow3Reset = 24'd262144;

   typedef struct packed {
      logic load;    // write incoming symbol at load position
      logic mac;     // accumulate one column
      logic first;   // first column: start a fresh sum
      logic red_q;   // reduction, quotient step
      logic red_r;   // reduction, remainder step
      logic shift;   // move sums one cell toward cell 0
   } cell_ctrl_type;

   // ASCII byte to alphabet index; anything unknown maps to ':' (44)
   function automatic logic [SymW-1:0] sym_index(input logic [CharW-1:0] c);
      logic [SymW-1:0] r;
      if (c >= 8'h30 && c <= 8'h39) r = SymW'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h5A) r = SymW'(c - 8'h37);
      else if (c == 8'h20) r = 6'd36;
      else if (c == 8'h24) r = 6'd37;
      else if (c == 8'h25) r = 6'd38;
      else if (c == 8'h2A) r = 6'd39;
      else if (c == 8'h2B) r = 6'd40;
      else if (c == 8'h2D) r = 6'd41;
      else if (c == 8'h2E) r = 6'd42;
      else if (c == 8'h2F) r = 6'd43;
      else r = 6'd44;
      return r;
   endfunction

   // alphabet index (0..44) back to ASCII
   function automatic logic [CharW-1:0] sym_char(input logic [SymW-1:0] s);
      logic [CharW-1:0] r;
      if (s < 6'd10) r = 8'h30 + CharW'(s);
      else if (s < 6'd36) r = 8'h37 + CharW'(s);
      else begin
         unique case (s)
            6'd36:   r = 8'h20;
            6'd37:   r = 8'h24;
            6'd38:   r = 8'h25;
            6'd39:   r = 8'h2A;
            6'd40:   r = 8'h2B;
            6'd41:   r = 8'h2D;
            6'd42:   r = 8'h2E;
            6'd43:   r = 8'h2F;
            default: r = 8'h3A;
         endcase
      end
      return r;
   endfunction

endpackage

[src/hcbt_req_if.sv]
// Input channel: one ASCII character per transaction.
// Depends on hcbt_pkg for the character width.
interface hcbt_req_if;
   logic                     valid;
   logic                     ready;
   logic [hcbt_pkg::CharW-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

[src/hcbt_rsp_if.sv]
// Result channel: one transformed character per transaction, with block end flag.
// Depends on hcbt_pkg for the character width.
interface hcbt_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [hcbt_pkg::CharW-1:0] out_char;
   logic                     block_end;

   modport source (output valid, output out_char, output block_end, input ready);
   modport sink   (input valid, input out_char, input block_end, output ready);
endinterface

[src/hill_cipher_block_transform_top.sv]
// Hill cipher block transform, modulo 45, as a row of MAX_BLOCK cells.
// Depends on hcbt_pkg, hcbt_req_if, hcbt_rsp_if and hcbt_cell.
//
// Usage:
//   req_chan carries one ASCII character per transaction. Characters are
//   mapped to the 45-symbol alphabet (unknown bytes become ':') and held in
//   the cells until a full block of n = clamp(block_size, 2, MAX_BLOCK)
//   symbols is present. A partial block stays held indefinitely.
//   The block then computes key * symbols modulo 45 and sends n characters
//   on rsp_chan, block_end set on the last one.
//   csr_we/csr_index/csr_wdata write block_size (index 0) and key rows 0..3
//   (indexes 1..4); other indexes are ignored. Write only while idle.
// Timing:
//   Characters are taken one per cycle while collecting. After the last one
//   of a block: multiply-accumulate over the n columns (one shared column
//   counter steps all rows at once), modulo reduction (quotient step, then
//   remainder step), then one result per cycle shifted out of cell 0 while
//   rsp_chan is not stalled. req_chan.ready is low from the end of a block
//   until its last result is in the output register.
// Reset: synchronous, clears the partial block count, restores block_size 2
//   and the identity key. rsp_chan stalls simply hold the output register
//   and pause the shift-out; nothing is dropped.
module hill_cipher_block_transform_top #(
   parameter int MAX_BLOCK = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   hcbt_req_if.sink                             req_chan,
   hcbt_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [hcbt_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [hcbt_pkg::CsrDataW-1:0]        csr_wdata
);

   localparam int IDX_W = $clog2(MAX_BLOCK);
   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   // largest unreduced row sum: MAX_BLOCK * 63 * 44
   localparam int SUM_W = $clog2(MAX_BLOCK * 63 * 44 + 1);

   // sequencer codes
   localparam logic [2:0] ST_COLLECT = 3'd0;
   localparam logic [2:0] ST_MAC     = 3'd1;
   localparam logic [2:0] ST_RED_Q   = 3'd2;
   localparam logic [2:0] ST_RED_R   = 3'd3;
   localparam logic [2:0] ST_OUT     = 3'd4;

   // configuration registers
   logic [hcbt_pkg::BlockSizeW-1:0] block_size_ff, block_size_in;
   logic [hcbt_pkg::KeyRowW-1:0]    key_row_ff [hcbt_pkg::KeyRows];
   logic [hcbt_pkg::KeyRowW-1:0]    key_row_in [hcbt_pkg::KeyRows];

   // control state
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] step_ff, step_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [hcbt_pkg::CharW-1:0] rsp_char_ff, rsp_char_in;
   logic                       rsp_end_ff, rsp_end_in;

   logic [CNT_W-1:0] n_eff;
   logic [CNT_W-1:0] fill_plus;
   logic             req_take;
   logic             step_last;
   logic             out_load;
   hcbt_pkg::cell_ctrl_type ctrl;

   logic [hcbt_pkg::SymW-1:0] cell_sym [MAX_BLOCK];
   logic [SUM_W-1:0]          cell_acc [MAX_BLOCK];
   logic [hcbt_pkg::SymW-1:0] new_sym;

   // ---- configuration port ----
   always_comb begin
      block_size_in = block_size_ff;
      for (int r = 0; r < hcbt_pkg::KeyRows; r++) key_row_in[r] = key_row_ff[r];
      if (csr_we) begin
         unique case (csr_index)
            hcbt_pkg::CsrBlockSize: block_size_in = csr_wdata[hcbt_pkg::BlockSizeW-1:0];
            hcbt_pkg::CsrKeyRow0:   key_row_in[0] = csr_wdata;
            hcbt_pkg::CsrKeyRow1:   key_row_in[1] = csr_wdata;
            hcbt_pkg::CsrKeyRow2:   key_row_in[2] = csr_wdata;
            hcbt_pkg::CsrKeyRow3:   key_row_in[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= hcbt_pkg::BlockSizeReset;
         key_row_ff[0] <= hcbt_pkg::KeyRow0Reset;
         key_row_ff[1] <= hcbt_pkg::KeyRow1Reset;
         key_row_ff[2] <= hcbt_pkg::KeyRow2Reset;
         key_row_ff[3] <= hcbt_pkg::KeyRow3Reset;
      end else begin
         block_size_ff <= block_size_in;
         for (int r = 0; r < hcbt_pkg::KeyRows; r++) key_row_ff[r] <= key_row_in[r];
      end
   end

   // effective block length, clamped to 2..MAX_BLOCK
   always_comb begin
      priority if (block_size_ff < 3'd2) n_eff = CNT_W'(2);
      else if (32'(block_size_ff) > MAX_BLOCK) n_eff = CNT_W'(MAX_BLOCK);
      else n_eff = CNT_W'(block_size_ff);
   end

   // ---- sequencer ----
   assign req_chan.ready = (state_ff == ST_COLLECT);
   assign req_take  = req_chan.valid && req_chan.ready;
   assign fill_plus = fill_ff + CNT_W'(1);
   assign step_last = (CNT_W'(step_ff) == n_eff - CNT_W'(1));
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   assign new_sym   = hcbt_pkg::sym_index(req_chan.char_code);

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_take) begin
               if (fill_plus >= n_eff) begin
                  fill_in  = '0;
                  step_in  = '0;
                  state_in = ST_MAC;
               end else begin
                  fill_in = fill_plus;
               end
            end
         end
         ST_MAC: begin
            if (step_last) begin
               step_in  = '0;
               state_in = ST_RED_Q;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         ST_RED_Q: state_in = ST_RED_R;
         ST_RED_R: state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) begin
               if (step_last) begin
                  step_in  = '0;
                  state_in = ST_COLLECT;
               end else begin
                  step_in = step_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         fill_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      ctrl.load  = req_take;
      ctrl.mac   = (state_ff == ST_MAC);
      ctrl.first = (step_ff == '0);
      ctrl.red_q = (state_ff == ST_RED_Q);
      ctrl.red_r = (state_ff == ST_RED_R);
      ctrl.shift = out_load;
   end

   // ---- cell row: row i sum in cell i, sums shift toward cell 0 ----
   for (genvar i = 0; i < MAX_BLOCK; i++) begin : g_cell
      logic [hcbt_pkg::KeyRowW-1:0] row_key;
      logic [SUM_W-1:0]             next_acc;

      if (i < hcbt_pkg::KeyRows) begin : g_key
         assign row_key = key_row_ff[i];
      end else begin : g_nokey
         assign row_key = '0;
      end

      if (i + 1 < MAX_BLOCK) begin : g_link
         assign next_acc = cell_acc[i + 1];
      end else begin : g_end
         assign next_acc = '0;
      end

      hcbt_cell #(
         .CELL_IDX (i),
         .IDX_W    (IDX_W),
         .SUM_W    (SUM_W)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .load_pos (fill_ff[IDX_W-1:0]),
         .load_sym (new_sym),
         .col      (step_ff),
         .key_row  (row_key),
         .x_sym    (cell_sym[step_ff]),
         .shift_in (next_acc),
         .sym      (cell_sym[i]),
         .acc      (cell_acc[i])
      );
   end

   // ---- result register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_end_in   = rsp_end_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = hcbt_pkg::sym_char(cell_acc[0][hcbt_pkg::SymW-1:0]);
         rsp_end_in   = step_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      rsp_char_ff <= rsp_char_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_char  = rsp_char_ff;
   assign rsp_chan.block_end = rsp_end_ff;

   // ---- checks ----
   a_fill_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COLLECT |-> 32'(fill_ff) < MAX_BLOCK)
      else $error("fill count reached buffer depth while collecting");

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && fill_plus >= n_eff) |=> (state_ff == ST_MAC && fill_ff == '0))
      else $error("full block did not start accumulation");

   a_last_result: assert property (@(posedge clock) disable iff (reset)
      (out_load && step_last) |=> (state_ff == ST_COLLECT && rsp_end_ff))
      else $error("last result not flagged or sequencer not back to collect");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC || state_ff == ST_OUT) |-> CNT_W'(step_ff) < n_eff)
      else $error("step counter past block length");

endmodule

[src/hcbt_cell.sv]
// One cell of the row: holds one buffered symbol and one row sum.
// Depends on hcbt_pkg (cell_ctrl_type, widths, modulus).
module hcbt_cell #(
   parameter int CELL_IDX = 0,
   parameter int IDX_W    = 2,
   parameter int SUM_W    = 14
) (
   input  logic                              clock,
   input  hcbt_pkg::cell_ctrl_type           ctrl,
   input  logic [IDX_W-1:0]                  load_pos,
   input  logic [hcbt_pkg::SymW-1:0]         load_sym,
   input  logic [IDX_W-1:0]                  col,
   input  logic [hcbt_pkg::KeyRowW-1:0]      key_row,
   input  logic [hcbt_pkg::SymW-1:0]         x_sym,
   input  logic [SUM_W-1:0]                  shift_in,
   output logic [hcbt_pkg::SymW-1:0]         sym,
   output logic [SUM_W-1:0]                  acc
);

   // floor(v * RECIP >> RECIP_SH) == v / 45 exactly for every v below 2**SUM_W
   localparam int RECIP_SH = SUM_W + 6;
   localparam int RECIP    = (2 ** RECIP_SH + hcbt_pkg::SymCount - 1) / hcbt_pkg::SymCount;
   localparam int QP_W     = 2 * SUM_W + 8;
   localparam int PROD_W   = hcbt_pkg::KeyEntryW + hcbt_pkg::SymW;

   logic [hcbt_pkg::SymW-1:0]      sym_ff, sym_in;
   logic [SUM_W-1:0]               acc_ff, acc_in;
   logic [SUM_W-1:0]               quo_ff, quo_in;
   logic [hcbt_pkg::KeyEntryW-1:0] key_entry;
   logic [PROD_W-1:0]              prod;
   logic [QP_W-1:0]                qprod;

   always_comb begin
      key_entry = '0;
      for (int e = 0; e < hcbt_pkg::KeyCols; e++) begin
         if (32'(col) == e) key_entry = key_row[e*hcbt_pkg::KeyEntryW +: hcbt_pkg::KeyEntryW];
      end
   end

   assign prod  = PROD_W'(key_entry) * PROD_W'(x_sym);
   assign qprod = QP_W'(acc_ff) * QP_W'(RECIP);

   always_comb begin
      sym_in = sym_ff;
      if (ctrl.load && (32'(load_pos) == CELL_IDX)) sym_in = load_sym;
   end

   always_comb begin
      acc_in = acc_ff;
      quo_in = quo_ff;
      priority if (ctrl.mac) begin
         acc_in = ctrl.first ? SUM_W'(prod) : acc_ff + SUM_W'(prod);
      end else if (ctrl.red_q) begin
         quo_in = qprod[RECIP_SH +: SUM_W];
      end else if (ctrl.red_r) begin
         acc_in = acc_ff - SUM_W'(quo_ff * SUM_W'(hcbt_pkg::SymCount));
      end else if (ctrl.shift) begin
         acc_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
   end

   assign sym = sym_ff;
   assign acc = acc_ff;

endmodule
